// ----- rtl/rdq_pkg.sv -----
package rdq_pkg;

  localparam int unsigned OpcodeWidth = 3;
  localparam int unsigned DataWidth   = 8;
  localparam int unsigned RotWidth    = 9;

  localparam logic [OpcodeWidth-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpcodeWidth-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpcodeWidth-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OpcodeWidth-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OpcodeWidth-1:0] OP_ROTATE     = 3'd4;
  localparam logic [OpcodeWidth-1:0] OP_REVERSE    = 3'd5;

endpackage

// ----- rtl/ring_deque_rotate_reverse.sv -----
// Byte deque held in a circular store of DEPTH entries.
// Input channel (in_valid_i / in_stall_o) carries one operation per item:
// push front/back, pop front/back, rotate by a signed amount, reverse.
// Output channel (out_valid_o / out_stall_i) returns one result item per
// operation: ok flag, popped byte (zero unless a pop succeeded), item count.
// One operation is in work at a time; in_stall_o stays high until its result
// is loaded into the output register.
// Steps from accept to result:
//   push, refused ops, unused codes, trivial rotate/reverse: from S_IDLE
//   pop: S_IDLE fetch, S_POP report (registered memory read)
//   rotate: S_DIV, S_FIX, then S_ROT_RD/S_ROT_WR for k items, k = rotate_by mod count;
//     the shared subtractor reduces the amount one count per cycle, then each
//     item moves front to back in a read state and a write state.
//   reverse: floor(count / 2) swaps of S_REV_RD, S_REV_WA, S_REV_WZ; each swap
//     needs two writes on the single memory write port after one dual-port read.
// Reset clears head, tail and count; store contents are left as they are.
// When the receiver stalls, the result holds in the output register and a
// new item is taken once that register drains.
module ring_deque_rotate_reverse
  import rdq_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [OpcodeWidth-1:0]           opcode_i,
  input  logic [DataWidth-1:0]             data_in_i,
  input  logic signed [RotWidth-1:0]       rotate_by_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             ok_o,
  output logic [DataWidth-1:0]             data_out_o,
  output logic [$clog2(DEPTH+1)-1:0]       item_count_o
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = (CW > RotWidth) ? CW : RotWidth;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_POP    = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_FIX    = 4'd3;
  localparam logic [3:0] S_ROT_RD = 4'd4;
  localparam logic [3:0] S_ROT_WR = 4'd5;
  localparam logic [3:0] S_REV_RD = 4'd6;
  localparam logic [3:0] S_REV_WA = 4'd7;
  localparam logic [3:0] S_REV_WZ = 4'd8;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
  endfunction

  logic [3:0]           state_q, state_d;
  logic [IW-1:0]        head_q, head_d, tail_q, tail_d;
  logic [IW-1:0]        ptr_a_q, ptr_a_d, ptr_z_q, ptr_z_d;
  logic [CW-1:0]        count_q, count_d;
  logic [MW-1:0]        rem_q, rem_d;
  logic                 neg_q, neg_d;
  logic                 out_valid_q, out_valid_d;
  logic                 ok_q, ok_d;
  logic [DataWidth-1:0] dout_q, dout_d;
  logic [CW-1:0]        ocnt_q, ocnt_d;

  logic [DataWidth-1:0] mem_q [DEPTH];
  logic [DataWidth-1:0] rd_a_q, rd_b_q;
  logic                 we, re_a, re_b;
  logic [IW-1:0]        waddr, raddr_a, raddr_b;
  logic [DataWidth-1:0] wdata;

  logic                 in_accept;
  logic [RotWidth-1:0]  rot_raw, rot_mag;
  logic [MW-1:0]        cnt_ext;
  logic [MW-1:0]        sub_a, sub_b, sub_diff;
  logic                 sub_borrow;

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign rot_raw = $unsigned(rotate_by_i);
  assign rot_mag = rot_raw[RotWidth-1] ? (~rot_raw + 1'b1) : rot_raw;
  assign cnt_ext = MW'(count_q);

  // Shared subtractor: amount reduction, negative correction, step counting
  always_comb begin
    unique case (state_q)
      S_DIV: begin
        sub_a = rem_q;
        sub_b = cnt_ext;
      end
      S_FIX: begin
        sub_a = cnt_ext;
        sub_b = rem_q;
      end
      default: begin
        sub_a = rem_q;
        sub_b = MW'(1);
      end
    endcase
  end
  assign {sub_borrow, sub_diff} = {1'b0, sub_a} - {1'b0, sub_b};

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    ptr_a_d  = ptr_a_q;
    ptr_z_d  = ptr_z_q;
    count_d  = count_q;
    rem_d    = rem_q;
    neg_d    = neg_q;
    ok_d     = ok_q;
    dout_d   = dout_q;
    ocnt_d   = ocnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    we      = 1'b0;
    waddr   = head_q;
    wdata   = data_in_i;
    re_a    = 1'b0;
    re_b    = 1'b0;
    raddr_a = head_q;
    raddr_b = tail_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          // Default result: refused, count unchanged
          out_valid_d = 1'b1;
          ok_d   = 1'b0;
          dout_d = '0;
          ocnt_d = count_q;
          unique case (opcode_i) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (count_q != CW'(DEPTH)) begin
                we      = 1'b1;
                ok_d    = 1'b1;
                count_d = count_q + 1'b1;
                ocnt_d  = count_q + 1'b1;
                if (count_q == '0) begin
                  waddr  = head_q;
                  tail_d = head_q;
                end else if (opcode_i == OP_PUSH_FRONT) begin
                  waddr  = idx_dec(head_q);
                  head_d = idx_dec(head_q);
                end else begin
                  waddr  = idx_inc(tail_q);
                  tail_d = idx_inc(tail_q);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (count_q != '0) begin
                // Fetch now, report next cycle
                out_valid_d = 1'b0;
                re_a    = 1'b1;
                raddr_a = (opcode_i == OP_POP_FRONT) ? head_q : tail_q;
                count_d = count_q - 1'b1;
                if (count_q != CW'(1)) begin
                  if (opcode_i == OP_POP_FRONT) begin
                    head_d = idx_inc(head_q);
                  end else begin
                    tail_d = idx_dec(tail_q);
                  end
                end
                state_d = S_POP;
              end
            end
            OP_ROTATE: begin
              ok_d = 1'b1;
              if (count_q != '0) begin
                out_valid_d = 1'b0;
                rem_d   = MW'(rot_mag);
                neg_d   = rot_raw[RotWidth-1];
                state_d = S_DIV;
              end
            end
            OP_REVERSE: begin
              ok_d = 1'b1;
              if (count_q > CW'(1)) begin
                out_valid_d = 1'b0;
                rem_d   = MW'(count_q >> 1);
                ptr_a_d = head_q;
                ptr_z_d = tail_q;
                state_d = S_REV_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_d = 1'b1;
        ok_d    = 1'b1;
        dout_d  = rd_a_q;
        ocnt_d  = count_q;
        state_d = S_IDLE;
      end
      S_DIV: begin
        if (!sub_borrow) begin
          rem_d = sub_diff;
        end else begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        // Negative amount: turn the remainder into a forward step count
        if (neg_q && rem_q != '0) begin
          rem_d = sub_diff;
        end
        state_d = S_ROT_RD;
      end
      S_ROT_RD: begin
        if (rem_q == '0) begin
          out_valid_d = 1'b1;
          ok_d    = 1'b1;
          dout_d  = '0;
          ocnt_d  = count_q;
          state_d = S_IDLE;
        end else begin
          re_a    = 1'b1;
          raddr_a = head_q;
          state_d = S_ROT_WR;
        end
      end
      S_ROT_WR: begin
        // Move the front item behind the back
        we      = 1'b1;
        waddr   = idx_inc(tail_q);
        wdata   = rd_a_q;
        tail_d  = idx_inc(tail_q);
        head_d  = idx_inc(head_q);
        rem_d   = sub_diff;
        state_d = S_ROT_RD;
      end
      S_REV_RD: begin
        re_a    = 1'b1;
        re_b    = 1'b1;
        raddr_a = ptr_a_q;
        raddr_b = ptr_z_q;
        state_d = S_REV_WA;
      end
      S_REV_WA: begin
        we      = 1'b1;
        waddr   = ptr_a_q;
        wdata   = rd_b_q;
        state_d = S_REV_WZ;
      end
      S_REV_WZ: begin
        we      = 1'b1;
        waddr   = ptr_z_q;
        wdata   = rd_a_q;
        ptr_a_d = idx_inc(ptr_a_q);
        ptr_z_d = idx_dec(ptr_z_q);
        rem_d   = sub_diff;
        if (rem_q == MW'(1)) begin
          out_valid_d = 1'b1;
          ok_d    = 1'b1;
          dout_d  = '0;
          ocnt_d  = count_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_REV_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re_a) begin
      rd_a_q <= mem_q[raddr_a];
    end
    if (re_b) begin
      rd_b_q <= mem_q[raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_a_q <= ptr_a_d;
    ptr_z_q <= ptr_z_d;
    rem_q   <= rem_d;
    neg_q   <= neg_d;
    ok_q    <= ok_d;
    dout_q  <= dout_d;
    ocnt_q  <= ocnt_d;
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign data_out_o   = dout_q;
  assign item_count_o = ocnt_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("item count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (opcode_i == OP_PUSH_FRONT || opcode_i == OP_PUSH_BACK)
      && count_q != CW'(DEPTH)
    |=> count_q == $past(count_q) + 1'b1 && out_valid_o && ok_o)
    else $error("push did not add one item");

  a_work_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |=> $stable(count_q))
    else $error("item count changed during multi-cycle work");

  a_no_result_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE && state_d != S_IDLE |=> !out_valid_o)
    else $error("result shown before work finished");
`endif

endmodule
